// ===== rtl/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants of the sliding window receiver: transfer
// payloads, register indexes, controller states and control bundles.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int unsigned SEQ_SLOTS_DEF   = 64;
  localparam int unsigned BUF_ENTRIES_DEF = 27;

  localparam int unsigned CFG_W    = 7;
  localparam int unsigned SEQ_W    = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST   = 7'd4;
  localparam logic [CFG_W-1:0] SEGMENT_LIMIT_RST = 7'd28;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LIMIT = 1'b1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq_num;
    logic [BYTE_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] out_byte;
    logic [SEQ_W-1:0]  next_expected;
    logic              dropped;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_BYTE,
    S_ACK
  } state_t;

  typedef struct packed {
    logic load_item;
    logic scan;
    logic rd_issue;
    logic drain_done;
    logic load_byte;
    logic load_ack;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic scan_hole;
    logic drain_empty;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/swr_ctrl.sv =====
// ----------------------------------------------------------------------------
// swr_ctrl
// Sequencer of the receiver: takes a segment, steps the hole scan, walks the
// byte drain and issues the acknowledgement.
// ----------------------------------------------------------------------------
module swr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swr_pkg::dp_sts_t sts,
  output swr_pkg::dp_cmd_t cmd
);
  import swr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_READ;
        end else if (sts.scan_hole) begin
          state_nxt = S_ACK;
        end
      end
      S_READ: begin
        if (!sts.out_busy) begin
          if (sts.drain_empty) begin
            cmd.drain_done = 1'b1;
            state_nxt      = S_ACK;
          end else begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_BYTE;
          end
        end
      end
      S_BYTE: begin
        cmd.load_byte = 1'b1;
        state_nxt     = S_READ;
      end
      S_ACK: begin
        if (!sts.out_busy) begin
          cmd.load_ack = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/swr_dp.sv =====
// ----------------------------------------------------------------------------
// swr_dp
// Datapath of the receiver: window registers, received map, byte store,
// hole scan pointer and the result register.
// ----------------------------------------------------------------------------
module swr_dp #(
  parameter int unsigned SEQ_SLOTS   = swr_pkg::SEQ_SLOTS_DEF,
  parameter int unsigned BUF_ENTRIES = swr_pkg::BUF_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swr_pkg::in_item_t                  in_data,
  output swr_pkg::out_item_t                 out_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               cfg_valid,
  input  logic [swr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swr_pkg::CFG_W-1:0]          cfg_wdata,
  input  swr_pkg::dp_cmd_t                   cmd,
  output swr_pkg::dp_sts_t                   sts
);
  import swr_pkg::*;

  localparam int unsigned MAP_IDX_W = $clog2(SEQ_SLOTS);
  localparam int unsigned CNT_W     = $clog2(BUF_ENTRIES + 1);
  localparam int unsigned IDX_W     = (BUF_ENTRIES > 1) ? $clog2(BUF_ENTRIES) : 1;

  logic [CFG_W-1:0]        window_size_r;
  logic [CFG_W-1:0]        segment_limit_r;
  logic signed [CFG_W-1:0] lio_r;
  logic [CFG_W-1:0]        pos_r;
  logic [SEQ_SLOTS-1:0]    map_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        rd_idx_r;
  logic [BYTE_W-1:0]       mem [BUF_ENTRIES];
  logic [BYTE_W-1:0]       rd_data_r;
  logic [SEQ_W-1:0]        next_r;
  logic                    drop_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [CFG_W-1:0]        lim;
  logic signed [8:0]       sum_s;
  logic signed [8:0]       top_s;
  logic signed [8:0]       bound_s;
  logic                    full;
  logic                    seq_in_range;
  logic                    map_bit;

  assign lim   = (segment_limit_r > CFG_W'(SEQ_SLOTS)) ? CFG_W'(SEQ_SLOTS) : segment_limit_r;
  assign sum_s = $signed({{2{lio_r[CFG_W-1]}}, lio_r}) + $signed({2'b00, window_size_r});
  assign top_s = $signed({2'b00, lim}) - 9'sd1;
  assign bound_s = (sum_s < top_s) ? sum_s : top_s;

  assign full         = (cnt_r == CNT_W'(BUF_ENTRIES));
  assign seq_in_range = ({1'b0, in_data.seq_num} < lim);
  assign map_bit      = map_r[pos_r[MAP_IDX_W-1:0]];

  assign sts.scan_end    = ($signed({2'b00, pos_r}) > bound_s);
  assign sts.scan_hole   = !sts.scan_end && !map_bit;
  assign sts.drain_empty = (rd_idx_r == cnt_r);
  assign sts.out_busy    = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_SIZE_RST;
      segment_limit_r <= SEGMENT_LIMIT_RST;
      lio_r           <= -7'sd1;
      map_r           <= '0;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW_SIZE:   window_size_r   <= cfg_wdata;
          REG_SEGMENT_LIMIT: segment_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load_item) begin
        if (!full) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (seq_in_range) begin
          map_r[in_data.seq_num[MAP_IDX_W-1:0]] <= 1'b1;
        end
      end
      if (cmd.scan && sts.scan_hole) begin
        lio_r <= $signed(pos_r) - 7'sd1;
      end
      if (cmd.drain_done) begin
        map_r <= '0;
        cnt_r <= '0;
        lio_r <= -7'sd1;
      end
      if (cmd.load_byte || cmd.load_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan pointer, drain pointer and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos_r    <= unsigned'(lio_r + 7'sd1);
      rd_idx_r <= '0;
      drop_r   <= full;
    end
    if (cmd.scan && !sts.scan_end && !sts.scan_hole) begin
      pos_r <= pos_r + CFG_W'(1);
    end
    if (cmd.scan && sts.scan_hole) begin
      next_r <= pos_r[SEQ_W-1:0];
    end
    if (cmd.drain_done) begin
      next_r <= '0;
    end
    if (cmd.rd_issue) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    if (cmd.load_byte) begin
      out_data_r.kind          <= KIND_BYTE;
      out_data_r.out_byte      <= rd_data_r;
      out_data_r.next_expected <= '0;
      out_data_r.dropped       <= 1'b0;
      out_data_r.last          <= 1'b0;
    end else if (cmd.load_ack) begin
      out_data_r.kind          <= KIND_ACK;
      out_data_r.out_byte      <= '0;
      out_data_r.next_expected <= next_r;
      out_data_r.dropped       <= drop_r;
      out_data_r.last          <= 1'b1;
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.load_item && !full) begin
      mem[cnt_r[IDX_W-1:0]] <= in_data.payload;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

endmodule

// ===== rtl/sliding_window_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_receiver_top
// Sliding window receiver with selective acknowledgement.
//
// Segments (seq_num, payload) arrive on the in_ channel, one transfer each.
// Each payload byte joins an arrival-order store unless it is full. The slot
// of the segment is marked if below the limit, then a scan walks from one
// past the last in-order slot to the window bound, one slot per cycle,
// looking for a hole. A hole becomes next_expected; with no hole every
// stored byte goes out on the out_ channel in arrival order (kind byte) and
// the window restarts at zero. Every segment ends with one acknowledgement
// transfer (kind ack, last set). A segment is taken, then scanned over at
// most 64 slots; when draining, each stored byte is read through the byte
// store's single read port and loaded into the output register, and the ack
// comes last; the out_ receiver can stall the bytes and the ack. A result
// waits in an output register, so the next segment may be taken while the
// last ack is still pending. cfg_ writes are taken every cycle and belong
// only to idle periods. A synchronous reset clears the map and store count
// and loads window 4 and limit 28, with no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_receiver_top #(
  parameter int unsigned SEQ_SLOTS   = swr_pkg::SEQ_SLOTS_DEF,
  parameter int unsigned BUF_ENTRIES = swr_pkg::BUF_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  swr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swr_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swr_pkg::CFG_W-1:0]     cfg_wdata
);
  import swr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  swr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swr_dp #(
    .SEQ_SLOTS   (SEQ_SLOTS),
    .BUF_ENTRIES (BUF_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/swr_checker.sv =====
// ----------------------------------------------------------------------------
// swr_checker
// Port-level checks of the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module swr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input swr_pkg::out_item_t out_data
);
  import swr_pkg::*;

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one segment at a time
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a segment is in work");

  // only an acknowledgement may still wait while a new segment is taken
  a_idle_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_data.last && out_data.kind == KIND_ACK)
    else $error("byte result pending while idle");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_receiver_top swr_checker u_swr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_sliding_window_receiver_top.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_receiver_top
// Self-checking bench for the sliding window receiver. A scoreboard keeps its
// own copy of the received map, window and byte store and predicts every
// byte and acknowledgement transfer. Directed segments cover the field
// extremes, slots beyond the limit, duplicates, zero window, zero limit and
// out-of-range register values. Random phases then send shuffled, mostly
// complete sequences with noise under many window and limit settings, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_sliding_window_receiver_top;
  import swr_pkg::*;

  localparam int ITEM_TARGET  = 450;
  localparam int DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  class window_scoreboard;
    out_item_t         expected_q[$];
    int                errors;
    int                results_seen;
    int                drains;
    int                drops;
    logic [CFG_W-1:0]  window_size;
    logic [CFG_W-1:0]  segment_limit;
    bit [SEQ_SLOTS_DEF-1:0] rx_map;
    int                last_in_order;
    int                last_acceptable;
    logic [BYTE_W-1:0] byte_store[BUF_ENTRIES_DEF];
    int                byte_count;

    function new();
      window_size     = WINDOW_SIZE_RST;
      segment_limit   = SEGMENT_LIMIT_RST;
      rx_map          = '0;
      byte_count      = 0;
      last_in_order   = -1;
      last_acceptable = window_bound();
    endfunction

    function int slot_limit();
      if (segment_limit < SEQ_SLOTS_DEF) return int'(segment_limit);
      return int'(SEQ_SLOTS_DEF);
    endfunction

    function int window_bound();
      int b;
      int top;
      b   = last_in_order + int'(window_size);
      top = slot_limit() - 1;
      return (b < top) ? b : top;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_WINDOW_SIZE) window_size = val;
      else segment_limit = val;
      last_acceptable = window_bound();
    endfunction

    function void note_segment(in_item_t seg);
      out_item_t r;
      int        lim;
      int        nxt;
      bit        drop;
      bit        hole;
      lim  = slot_limit();
      nxt  = 0;
      drop = 1'b0;
      hole = 1'b0;
      if (byte_count < BUF_ENTRIES_DEF) begin
        byte_store[byte_count] = seg.payload;
        byte_count++;
      end else begin
        drop = 1'b1;
        drops++;
      end
      if (int'(seg.seq_num) < lim) rx_map[seg.seq_num] = 1'b1;
      for (int pos = last_in_order + 1; pos <= last_acceptable && pos < lim; pos++) begin
        if (!rx_map[pos]) begin
          nxt             = pos;
          last_in_order   = pos - 1;
          last_acceptable = window_bound();
          hole            = 1'b1;
          break;
        end
      end
      if (!hole) begin
        for (int i = 0; i < byte_count; i++) begin
          r          = '0;
          r.kind     = KIND_BYTE;
          r.out_byte = byte_store[i];
          expected_q.push_back(r);
        end
        byte_count      = 0;
        rx_map          = '0;
        last_in_order   = -1;
        last_acceptable = window_bound();
        nxt             = 0;
        drains++;
      end
      r               = '0;
      r.kind          = KIND_ACK;
      r.next_expected = nxt[SEQ_W-1:0];
      r.dropped       = drop;
      r.last          = 1'b1;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transfer %h", got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind %b, expected %b", got.kind, exp.kind));
      if (got.out_byte !== exp.out_byte)
        report($sformatf("out_byte %h, expected %h", got.out_byte, exp.out_byte));
      if (got.next_expected !== exp.next_expected)
        report($sformatf("next_expected %0d, expected %0d",
                         got.next_expected, exp.next_expected));
      if (got.dropped !== exp.dropped)
        report($sformatf("dropped %b, expected %b", got.dropped, exp.dropped));
      if (got.last !== exp.last)
        report($sformatf("last %b, expected %b", got.last, exp.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  window_scoreboard sb;
  bit               idle_on;
  int               segments_sent;
  int               reg_writes;
  int unsigned      cycle_count;

  sliding_window_receiver_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // transfer monitor: results first, then the segment taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_segment(in_data);
    end
  end

  // result side stalls
  initial begin
    int stall;
    forever begin
      stall = idle_on ? int'($urandom_range(0, 19)) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_segment(input logic [SEQ_W-1:0] seq, input logic [BYTE_W-1:0] data);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.seq_num <= seq;
    in_data.payload <= data;
    do @(posedge clk); while (!in_ready);
    segments_sent++;
  endtask

  task automatic settle_segments();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    reg_writes++;
  endtask

  task automatic set_window(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] l);
    if ($urandom_range(0, 1)) begin
      write_register(REG_WINDOW_SIZE, w);
      write_register(REG_SEGMENT_LIMIT, l);
    end else begin
      write_register(REG_SEGMENT_LIMIT, l);
      write_register(REG_WINDOW_SIZE, w);
    end
    cfg_valid <= 1'b0;
  endtask

  // one setting, then a shuffled run over the slots with some noise and gaps, or noise alone
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] l,
                           input bit noise_only);
    int order[$];
    int lim;
    int k;
    int tmp;
    set_window(w, l);
    idle_on = ($urandom_range(0, 3) != 0);
    lim = (l > CFG_W'(SEQ_SLOTS_DEF)) ? int'(SEQ_SLOTS_DEF) : int'(l);
    if (noise_only || lim == 0) begin
      repeat ($urandom_range(3, 12))
        send_segment(SEQ_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < lim; i++) order.push_back(i);
      for (int i = 0; i + 1 < lim; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          k = i + int'($urandom_range(1, 3));
          if (k >= lim) k = lim - 1;
          tmp      = order[i];
          order[i] = order[k];
          order[k] = tmp;
        end
      end
      foreach (order[j]) begin
        if ($urandom_range(0, 9) == 0)
          send_segment(SEQ_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) != 0)
          send_segment(SEQ_W'(order[j]), BYTE_W'($urandom_range(0, 255)));
      end
    end
    settle_segments();
  endtask

  initial begin
    int               sel;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] l;
    sb            = new();
    idle_on       = 1'b0;
    segments_sent = 0;
    reg_writes    = 0;
    cycle_count   = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: slot beyond the limit, gap, duplicate, fill-in
    send_segment(6'd63, 8'hFF);
    send_segment(6'd0, 8'h00);
    send_segment(6'd2, 8'h5A);
    send_segment(6'd0, 8'h33);
    send_segment(6'd1, 8'hC3);
    send_segment(6'd3, 8'h0F);
    settle_segments();
    // zero window drains on every segment
    set_window(7'd0, 7'd28);
    send_segment(6'd5, 8'h11);
    send_segment(6'd40, 8'h22);
    settle_segments();
    // zero limit
    set_window(7'd1, 7'd0);
    send_segment(6'd0, 8'h44);
    send_segment(6'd63, 8'h99);
    settle_segments();
    // register values above range
    set_window(7'd127, 7'd127);
    send_segment(6'd63, 8'h80);
    send_segment(6'd0, 8'h01);
    settle_segments();
    set_window(7'd1, 7'd1);
    send_segment(6'd1, 8'hAA);
    send_segment(6'd0, 8'h7E);
    settle_segments();
    idle_on = 1'b1;
    set_window(7'd64, 7'd64);
    send_segment(6'd1, 8'h12);
    send_segment(6'd0, 8'h34);
    send_segment(6'd2, 8'h56);
    settle_segments();

    // full slot range, overflows the byte store
    run_phase(7'd4, 7'd64, 1'b0);

    while (segments_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) l = CFG_W'($urandom_range(1, 10));
      else if (sel == 6) l = 7'd28;
      else if (sel == 7) l = 7'd64;
      else if (sel == 8) l = CFG_W'($urandom_range(65, 127));
      else l = CFG_W'($urandom_range(11, 40));
      sel = $urandom_range(0, 9);
      if (sel < 5) w = CFG_W'($urandom_range(1, 4));
      else if (sel < 7) w = CFG_W'($urandom_range(5, 16));
      else if (sel == 7) w = 7'd64;
      else if (sel == 8) w = 7'd0;
      else w = CFG_W'($urandom_range(65, 127));
      run_phase(w, l, $urandom_range(0, 5) == 0);
    end

    settle_segments();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    $display("run covered %0d segments, %0d result transfers, %0d register writes",
             segments_sent, sb.results_seen, reg_writes);
    $display("predicted %0d store drains and %0d dropped bytes", sb.drains, sb.drops);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swr_pkg.sv
rtl/swr_ctrl.sv
rtl/swr_dp.sv
rtl/sliding_window_receiver_top.sv
rtl/swr_checker.sv
bench/tb_sliding_window_receiver_top.sv
